// File: hw/rtl/c_source_delimiter_balance_checker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimiter balance checker
// Shared clocked assertion forms; reset disables checking in DBC_ASSERT only.
// ----------------------------------------------------------------------------
`ifndef C_SOURCE_DELIMITER_BALANCE_CHECKER_TOP_ASSERT_SVH
`define C_SOURCE_DELIMITER_BALANCE_CHECKER_TOP_ASSERT_SVH

// Check a property on every rising edge outside reset
`define DBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define DBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dbc_pkg.sv
// ----------------------------------------------------------------------------
// Delimiter balance checker package
// Shared constants, character codes, counter indexes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package dbc_pkg;

  // Counter width and count of counters
  localparam int CountBits = 16;
  localparam int NumCounts = 10;

  // Result bus: ten counts, balanced flag, zero fill to whole bytes
  localparam int OutUsedBits  = NumCounts * CountBits + 1;
  localparam int OutTdataBits = ((OutUsedBits + 7) / 8) * 8;
  localparam int BalancedBit  = NumCounts * CountBits;

  // Counter indexes, in result order
  localparam int IxOpenParen    = 0;
  localparam int IxCloseParen   = 1;
  localparam int IxOpenBracket  = 2;
  localparam int IxCloseBracket = 3;
  localparam int IxOpenBrace    = 4;
  localparam int IxCloseBrace   = 5;
  localparam int IxOpenSq       = 6;
  localparam int IxCloseSq      = 7;
  localparam int IxOpenDq       = 8;
  localparam int IxCloseDq      = 9;

  // Character codes
  localparam logic [7:0] ChOpenBrace    = 8'h7B;
  localparam logic [7:0] ChCloseBrace   = 8'h7D;
  localparam logic [7:0] ChOpenParen    = 8'h28;
  localparam logic [7:0] ChCloseParen   = 8'h29;
  localparam logic [7:0] ChOpenBracket  = 8'h5B;
  localparam logic [7:0] ChCloseBracket = 8'h5D;
  localparam logic [7:0] ChDoubleQuote  = 8'h22;
  localparam logic [7:0] ChSingleQuote  = 8'h27;
  localparam logic [7:0] ChBackslash    = 8'h5C;
  localparam logic [7:0] ChStar         = 8'h2A;
  localparam logic [7:0] ChSlash        = 8'h2F;
  localparam logic [7:0] ChNewline      = 8'h0A;
  localparam logic [7:0] ChNone         = 8'h00;

  // Lexical context flags
  typedef struct packed {
    logic comment_active;
    logic comment_is_block;
    logic in_single_quote;
    logic in_double_quote;
  } flags_t;

  // One accepted input item, as held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef logic [NumCounts-1:0] bump_t;

endpackage

`default_nettype wire

// File: hw/rtl/dbc_judge.sv
// ----------------------------------------------------------------------------
// Delimiter balance checker byte judge
// Judges one byte against its previous and next byte: updates the comment
// and quote context and flags which counters advance.
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_judge (
  input  wire logic           en,
  input  wire logic [7:0]     cur_byte,
  input  wire logic [7:0]     prev_byte,
  input  wire logic [7:0]     next_byte,
  input  wire dbc_pkg::flags_t flags_in,
  output dbc_pkg::flags_t     flags_out,
  output dbc_pkg::bump_t      bump
);

  logic block_end;
  logic line_end;
  logic comment_start;
  logic escaped;
  logic quote_open;

  assign block_end     = flags_in.comment_is_block && (cur_byte == dbc_pkg::ChStar) &&
                         (next_byte == dbc_pkg::ChSlash);
  assign line_end      = !flags_in.comment_is_block && (cur_byte == dbc_pkg::ChNewline);
  assign comment_start = (cur_byte == dbc_pkg::ChSlash) &&
                         ((next_byte == dbc_pkg::ChSlash) || (next_byte == dbc_pkg::ChStar));
  assign escaped       = (prev_byte == dbc_pkg::ChBackslash);
  assign quote_open    = flags_in.in_single_quote || flags_in.in_double_quote;

  // Update context and pick the counter to advance
  always_comb begin
    flags_out = flags_in;
    bump      = '0;
    if (!en) begin
      flags_out = flags_in;
    end else if (flags_in.comment_active) begin
      // inside a comment: only look for its end
      if (block_end || line_end) begin
        flags_out.comment_active   = 1'b0;
        flags_out.comment_is_block = 1'b0;
      end
    end else if (comment_start) begin
      flags_out.comment_active = 1'b1;
      if (next_byte == dbc_pkg::ChStar) begin
        flags_out.comment_is_block = 1'b1;
      end
    end else if (escaped) begin
      flags_out = flags_in;
    end else if (!quote_open) begin
      unique case (cur_byte)
        dbc_pkg::ChOpenBrace:    bump[dbc_pkg::IxOpenBrace]    = 1'b1;
        dbc_pkg::ChCloseBrace:   bump[dbc_pkg::IxCloseBrace]   = 1'b1;
        dbc_pkg::ChOpenParen:    bump[dbc_pkg::IxOpenParen]    = 1'b1;
        dbc_pkg::ChCloseParen:   bump[dbc_pkg::IxCloseParen]   = 1'b1;
        dbc_pkg::ChOpenBracket:  bump[dbc_pkg::IxOpenBracket]  = 1'b1;
        dbc_pkg::ChCloseBracket: bump[dbc_pkg::IxCloseBracket] = 1'b1;
        dbc_pkg::ChDoubleQuote: begin
          flags_out.in_double_quote = 1'b1;
          bump[dbc_pkg::IxOpenDq]   = 1'b1;
        end
        dbc_pkg::ChSingleQuote: begin
          flags_out.in_single_quote = 1'b1;
          bump[dbc_pkg::IxOpenSq]   = 1'b1;
        end
        default: bump = '0;
      endcase
    end else if ((cur_byte == dbc_pkg::ChDoubleQuote) && flags_in.in_double_quote) begin
      flags_out.in_double_quote = 1'b0;
      bump[dbc_pkg::IxCloseDq]  = 1'b1;
    end else if ((cur_byte == dbc_pkg::ChSingleQuote) && flags_in.in_single_quote) begin
      flags_out.in_single_quote = 1'b0;
      bump[dbc_pkg::IxCloseSq]  = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dbc_in_stage.sv
// ----------------------------------------------------------------------------
// Delimiter balance checker input stage
// Registers each accepted byte; frees the slot when the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  input  wire logic       take,
  output dbc_pkg::item_t  item
);

  // Accept when empty or when the held item leaves this cycle; hold off in reset
  assign s_tready = !rst && (!item.valid || take);

  // Clear valid under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (s_tready) begin
      item.valid <= s_tvalid;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data_byte <= s_tdata;
      item.last_byte <= s_tlast;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/c_source_delimiter_balance_checker_top.sv
// A result is registered in the output register when its last byte leaves the input register.
// Throughput: one byte per cycle; a final byte waits in the input register
// while an earlier result is still held in the output register, and the
// input stalls behind it until that result is taken.
// Reset (rst, synchronous) empties both registers and clears all counts and
// comment/quote context; the counts also clear after every final byte.
// ----------------------------------------------------------------------------
// C source delimiter balance checker
// Tracks comments and quotes in a byte stream and counts delimiters, with one
// byte of lookahead, and emits the counts and a balanced flag per stream.
// ----------------------------------------------------------------------------
`default_nettype none

module c_source_delimiter_balance_checker_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,  // [7:0] data_byte
  input  wire logic                              s_tlast,  // last_byte
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // 16 bits each from bit 0: open_paren, close_paren, open_bracket,
  // close_bracket, open_brace, close_brace, open_single_quote,
  // close_single_quote, open_double_quote, close_double_quote;
  // then all_balanced, then zero fill
  output logic [dbc_pkg::OutTdataBits-1:0]       m_tdata
);

  dbc_pkg::item_t  item;
  logic            take;

  // Context state
  logic [7:0]                      held_byte;
  logic                            held_valid;
  logic [7:0]                      byte_before_held;
  dbc_pkg::flags_t                 flags;
  logic [dbc_pkg::CountBits-1:0]   counts [dbc_pkg::NumCounts];

  // Judge outputs
  dbc_pkg::flags_t                 flags_mid;
  dbc_pkg::flags_t                 flags_end;
  dbc_pkg::bump_t                  bump_held;
  dbc_pkg::bump_t                  bump_last;
  logic [7:0]                      prev_mid;
  logic [dbc_pkg::CountBits-1:0]   counts_next [dbc_pkg::NumCounts];
  logic                            balanced;
  logic [dbc_pkg::OutTdataBits-1:0] result;

  dbc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .take     (take),
    .item     (item)
  );

  // Take the held item unless it is final and the result slot is blocked
  assign take = item.valid && (!item.last_byte || !m_tvalid || m_tready);

  // Judge the held byte with the new byte as lookahead
  dbc_judge u_judge_held (
    .en        (held_valid),
    .cur_byte  (held_byte),
    .prev_byte (byte_before_held),
    .next_byte (item.data_byte),
    .flags_in  (flags),
    .flags_out (flags_mid),
    .bump      (bump_held)
  );

  assign prev_mid = held_valid ? held_byte : byte_before_held;

  // On the final byte, judge it too with no lookahead
  dbc_judge u_judge_last (
    .en        (item.last_byte),
    .cur_byte  (item.data_byte),
    .prev_byte (prev_mid),
    .next_byte (dbc_pkg::ChNone),
    .flags_in  (flags_mid),
    .flags_out (flags_end),
    .bump      (bump_last)
  );

  // Advance counters by up to two, saturating
  always_comb begin
    logic [1:0]                    inc;
    logic [dbc_pkg::CountBits:0]   sum;
    for (int k = 0; k < dbc_pkg::NumCounts; k++) begin
      inc = {1'b0, bump_held[k]} + {1'b0, bump_last[k]};
      sum = {1'b0, counts[k]} + {{(dbc_pkg::CountBits-1){1'b0}}, inc};
      counts_next[k] = sum[dbc_pkg::CountBits] ? '1 : sum[dbc_pkg::CountBits-1:0];
    end
  end

  // Compare each open count with its close count and pack the result
  always_comb begin
    balanced = 1'b1;
    result   = '0;
    for (int k = 0; k < dbc_pkg::NumCounts; k += 2) begin
      if (counts_next[k] != counts_next[k+1]) begin
        balanced = 1'b0;
      end
    end
    for (int k = 0; k < dbc_pkg::NumCounts; k++) begin
      result[k*dbc_pkg::CountBits +: dbc_pkg::CountBits] = counts_next[k];
    end
    result[dbc_pkg::BalancedBit] = balanced;
  end

  // Update context; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte        <= '0;
      held_valid       <= 1'b0;
      byte_before_held <= '0;
      flags            <= '0;
      for (int k = 0; k < dbc_pkg::NumCounts; k++) begin
        counts[k] <= '0;
      end
    end else if (take) begin
      if (item.last_byte) begin
        held_byte        <= '0;
        held_valid       <= 1'b0;
        byte_before_held <= '0;
        flags            <= '0;
        for (int k = 0; k < dbc_pkg::NumCounts; k++) begin
          counts[k] <= '0;
        end
      end else begin
        held_byte        <= item.data_byte;
        held_valid       <= 1'b1;
        byte_before_held <= prev_mid;
        flags            <= flags_mid;
        for (int k = 0; k < dbc_pkg::NumCounts; k++) begin
          counts[k] <= counts_next[k];
        end
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && item.last_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_byte) begin
      m_tdata <= result;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dbc_checker.sv
// ----------------------------------------------------------------------------
// Delimiter balance checker port checker
// Watches the top-level ports for result hold, flag consistency, input
// stalls and reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_source_delimiter_balance_checker_top_assert.svh"

module dbc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [dbc_pkg::OutTdataBits-1:0]  m_tdata
);

  logic balanced_expect;
  logic balanced_seen;

  assign balanced_seen = m_tdata[dbc_pkg::BalancedBit];

  // Balanced flag follows the reported pairs
  always_comb begin
    balanced_expect = 1'b1;
    for (int k = 0; k < dbc_pkg::NumCounts; k += 2) begin
      if (m_tdata[k*dbc_pkg::CountBits +: dbc_pkg::CountBits] !=
          m_tdata[(k+1)*dbc_pkg::CountBits +: dbc_pkg::CountBits]) begin
        balanced_expect = 1'b0;
      end
    end
  end

  `DBC_ASSERT(a_result_held, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
  `DBC_ASSERT(a_result_stable, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result moved")
  `DBC_ASSERT(a_balanced_flag, m_tvalid |-> (balanced_seen == balanced_expect), "bad balanced")
  `DBC_ASSERT_ALWAYS(a_stall_cause, (!rst && !s_tready) |-> (m_tvalid && !m_tready), "bad stall")
  `DBC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "result valid after reset")

endmodule

bind c_source_delimiter_balance_checker_top dbc_checker u_dbc_checker (.*);

`default_nettype wire

// File: verif/dbc_tally_checker.sv
// ----------------------------------------------------------------------------
// Delimiter tally checker
// Watches both item channels of the delimiter balance checker, predicts the
// ten delimiter counts and the balanced flag of every stream from the bytes
// accepted, and compares each result item field by field with the oldest
// prediction. Hands its mismatch count and open predictions to the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_tally_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  input  wire logic                              s_tready,
  input  wire logic [7:0]                        s_tdata,  // [7:0] data_byte
  input  wire logic                              s_tlast,  // last_byte
  input  wire logic                              m_tvalid,
  input  wire logic                              m_tready,
  // 16 bits per count from bit 0, then all_balanced, then zero fill
  input  wire logic [dbc_pkg::OutTdataBits-1:0]  m_tdata,
  output int                                     error_count,
  output int                                     open_tallies
);

  import dbc_pkg::*;

  localparam int FieldBits = 16;

  typedef struct packed {
    logic                                   balanced;
    logic [NumCounts-1:0][FieldBits-1:0]    counts;
  } tally_t;

  // Predicted results of finished streams, oldest first
  tally_t tally_q[$];

  // Lexical context of the stream in progress
  logic [7:0]           held_ch;
  logic                 held_ok;
  logic [7:0]           prior_ch;
  flags_t               ctx;
  logic [CountBits-1:0] tally [NumCounts];

  function automatic string field_label(int k);
    case (k)
      IxOpenParen:    return "open_paren";
      IxCloseParen:   return "close_paren";
      IxOpenBracket:  return "open_bracket";
      IxCloseBracket: return "close_bracket";
      IxOpenBrace:    return "open_brace";
      IxCloseBrace:   return "close_brace";
      IxOpenSq:       return "open_single_quote";
      IxCloseSq:      return "close_single_quote";
      IxOpenDq:       return "open_double_quote";
      default:        return "close_double_quote";
    endcase
  endfunction

  task automatic clear_context();
    held_ch  = ChNone;
    held_ok  = 1'b0;
    prior_ch = ChNone;
    ctx      = '0;
    for (int k = 0; k < NumCounts; k++) tally[k] = '0;
  endtask

  // Count one delimiter, holding at the top value
  task automatic bump(int ix);
    if (tally[ix] != {CountBits{1'b1}}) tally[ix] = tally[ix] + 1'b1;
  endtask

  // Judge byte c given the byte before it (p) and the lookahead byte (n)
  task automatic judge_char(logic [7:0] c, logic [7:0] p, logic [7:0] n);
    if (ctx.comment_active) begin
      if (ctx.comment_is_block && c == ChStar && n == ChSlash) begin
        ctx.comment_active   = 1'b0;
        ctx.comment_is_block = 1'b0;
      end
      if (c == ChNewline && !ctx.comment_is_block) begin
        ctx.comment_active   = 1'b0;
        ctx.comment_is_block = 1'b0;
      end
    end else if (c == ChSlash && (n == ChSlash || n == ChStar)) begin
      // a comment opens even inside a quote
      ctx.comment_active = 1'b1;
      if (n == ChStar) ctx.comment_is_block = 1'b1;
    end else if (p != ChBackslash) begin
      if (!ctx.in_single_quote && !ctx.in_double_quote) begin
        case (c)
          ChOpenBrace:    bump(IxOpenBrace);
          ChCloseBrace:   bump(IxCloseBrace);
          ChOpenParen:    bump(IxOpenParen);
          ChCloseParen:   bump(IxCloseParen);
          ChOpenBracket:  bump(IxOpenBracket);
          ChCloseBracket: bump(IxCloseBracket);
          ChDoubleQuote: begin
            ctx.in_double_quote = 1'b1;
            bump(IxOpenDq);
          end
          ChSingleQuote: begin
            ctx.in_single_quote = 1'b1;
            bump(IxOpenSq);
          end
          default: ;
        endcase
      end else if (c == ChDoubleQuote && ctx.in_double_quote) begin
        ctx.in_double_quote = 1'b0;
        bump(IxCloseDq);
      end else if (c == ChSingleQuote && ctx.in_single_quote) begin
        ctx.in_single_quote = 1'b0;
        bump(IxCloseSq);
      end
    end
  endtask

  // Advance the prediction by one accepted item
  task automatic take_byte(logic [7:0] b, logic fin);
    tally_t t;
    if (held_ok) begin
      judge_char(held_ch, prior_ch, b);
      prior_ch = held_ch;
    end
    held_ch = b;
    held_ok = 1'b1;
    if (fin) begin
      // final byte sees no lookahead
      judge_char(held_ch, prior_ch, ChNone);
      t.balanced = 1'b1;
      for (int k = 0; k < NumCounts; k += 2)
        if (tally[k] != tally[k+1]) t.balanced = 1'b0;
      for (int k = 0; k < NumCounts; k++)
        t.counts[k] = (tally[k] > 'hFFFF) ? 16'hFFFF : FieldBits'(tally[k]);
      tally_q.push_back(t);
      clear_context();
    end
  endtask

  task automatic note_miss(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Compare one result item with the oldest prediction
  task automatic check_result(logic [OutTdataBits-1:0] bus);
    tally_t want;
    if (tally_q.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch at %0t: result item with no prediction waiting", $realtime);
    end else begin
      want = tally_q.pop_front();
      for (int k = 0; k < NumCounts; k++)
        if (bus[k*FieldBits +: FieldBits] !== want.counts[k])
          note_miss(field_label(k), want.counts[k], bus[k*FieldBits +: FieldBits]);
      if (bus[BalancedBit] !== want.balanced)
        note_miss("all_balanced", want.balanced, bus[BalancedBit]);
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_context();
      tally_q.delete();
      error_count = 0;
    end else begin
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_result(m_tdata);
    end
    open_tallies <= tally_q.size();
  end

endmodule

`default_nettype wire

// File: verif/tb_c_source_delimiter_balance_checker_top.sv
// ----------------------------------------------------------------------------
// Delimiter balance checker testbench
// Feeds directed C fragments and random token streams through the block with
// random idling on both sides, a long output hold-off and drain pauses; a
// separate checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_c_source_delimiter_balance_checker_top;

  import dbc_pkg::*;

  localparam int Limit      = 100_000;
  localparam int HoldCycles = 300;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [7:0]              s_tdata;
  logic                    s_tlast;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OutTdataBits-1:0] m_tdata;
  int                      error_count;
  int                      open_tallies;

  logic                    idle_on;
  logic                    hold_req;
  logic [7:0]              frame_q[$];

  c_source_delimiter_balance_checker_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dbc_tally_checker tally_chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .error_count  (error_count),
    .open_tallies (open_tallies)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < Limit) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Drive the result side: random stalls, one long hold-off on request
  initial begin
    bit held_once;
    held_once = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_item(logic [7:0] b, logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_item(txt[i], i == txt.len() - 1);
  endtask

  // Send the built frame as one stream and empty it
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_item(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // Stop offering and pause until every predicted result has come out
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_tallies != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0:  return ChOpenParen;
      1:  return ChCloseParen;
      2:  return ChOpenBracket;
      3:  return ChCloseBracket;
      4:  return ChOpenBrace;
      5:  return ChCloseBrace;
      6:  return ChSingleQuote;
      7:  return ChDoubleQuote;
      8:  return ChBackslash;
      9:  return ChStar;
      10: return ChSlash;
      11: return ChNewline;
      12: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  task automatic add_filler(int most);
    repeat ($urandom_range(0, most)) frame_q.push_back(pick_char());
  endtask

  // Append one C-like token to the frame; some are left unterminated
  task automatic add_token();
    case ($urandom_range(0, 9))
      0: begin
        frame_q.push_back(ChSlash);
        frame_q.push_back(ChStar);
        add_filler(4);
        if ($urandom_range(0, 5) != 0) begin
          frame_q.push_back(ChStar);
          frame_q.push_back(ChSlash);
        end
      end
      1: begin
        frame_q.push_back(ChSlash);
        frame_q.push_back(ChSlash);
        add_filler(4);
        if ($urandom_range(0, 5) != 0) frame_q.push_back(ChNewline);
      end
      2: begin
        frame_q.push_back(ChDoubleQuote);
        add_filler(4);
        if ($urandom_range(0, 5) != 0) frame_q.push_back(ChDoubleQuote);
      end
      3: begin
        frame_q.push_back(ChSingleQuote);
        add_filler(1);
        if ($urandom_range(0, 5) != 0) frame_q.push_back(ChSingleQuote);
      end
      4: begin
        frame_q.push_back(ChBackslash);
        frame_q.push_back(pick_char());
      end
      5: begin
        frame_q.push_back(ChOpenParen);
        add_filler(3);
        frame_q.push_back(ChCloseParen);
      end
      6: frame_q.push_back(8'($urandom_range(0, 255)));
      default: frame_q.push_back(pick_char());
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    int sent;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= ChNone;
    s_tlast  <= 1'b0;
    idle_on  <= 1'b1;
    hold_req <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed fragments: lone byte, block and line comments, escaped quote,
    // escape chain with byte extremes and a trailing slash, comment in quote
    send_text("(");
    send_text("/*[*/]");
    send_text("//{\n}");
    send_text("\"\\\"'\"");
    send_item(ChBackslash, 1'b0);
    send_item(ChBackslash, 1'b0);
    send_item(ChOpenParen, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(ChSlash, 1'b1);
    send_text("'/*");
    wait_drain();

    // Hold the result side off while short streams keep coming
    hold_req <= 1'b1;
    repeat (6) begin
      repeat ($urandom_range(1, 3)) frame_q.push_back(pick_char());
      send_frame();
    end
    wait_drain();

    // Random token streams, idling switched off for the last part
    sent = 0;
    while (sent < 500) begin
      if (sent >= 400) idle_on <= 1'b0;
      repeat ($urandom_range(1, 6)) add_token();
      sent += frame_q.size();
      send_frame();
    end
    s_tvalid <= 1'b0;

    wait_drain();
    repeat (8) @(posedge clk);
    if (error_count == 0 && open_tallies == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
